// ===== sv/xdh_pkg.sv =====
// Shared constants, types and codes of the XOR-delta rolling window hash.
`timescale 1ns / 1ps

package xdh_pkg;

    localparam int          XDH_MAX_WINDOW = 256;
    localparam int          XDH_OUT_DEPTH  = 16;
    localparam int          XDH_VAL_W      = 30;
    localparam int          XDH_POS_W      = 16;
    localparam int          XDH_LEN_W      = 9;

    localparam logic [29:0] XDH_PRIME  = 30'd1073741789;   // 2^30 - 35
    localparam logic [31:0] XDH_PRIME2 = 32'd2147483578;   // twice the prime
    localparam logic [10:0] XDH_BASE   = 11'd1031;
    localparam logic [5:0]  XDH_FOLD   = 6'd35;            // 2^30 mod prime

    typedef enum logic [1:0] {
        CFG_WIN_LEN = 2'd0,
        CFG_TOP_POW = 2'd1
    } t_cfg_idx;

    // Sideband that travels with an item down the pipeline.
    typedef struct packed {
        logic                 vld;
        logic                 clr;
        logic                 drop;
        logic                 emit;
        logic [XDH_VAL_W-1:0] diff;
        logic [XDH_POS_W-1:0] pos;
    } t_xdh_tag;

endpackage

// ===== sv/xdh_win_mem.sv =====
// Window store: one write port and one read port, read data registered, read-first.
`timescale 1ns / 1ps

module xdh_win_mem #(
    parameter int DEPTH = xdh_pkg::XDH_MAX_WINDOW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [xdh_pkg::XDH_VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [xdh_pkg::XDH_VAL_W-1:0] o_rdata
);
    import xdh_pkg::*;

    logic [XDH_VAL_W-1:0] r_mem [DEPTH];
    logic [XDH_VAL_W-1:0] r_rdata;

    // Read returns the old entry when both ports hit the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/xdh_drop_unit.sv =====
// Drop term: top_power times the oldest value, reduced, then scaled by the base.
`timescale 1ns / 1ps

module xdh_drop_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xdh_pkg::t_xdh_tag             i_tag,
    input  logic [xdh_pkg::XDH_VAL_W-1:0] i_old,
    input  logic [xdh_pkg::XDH_VAL_W-1:0] i_top_pow,
    output xdh_pkg::t_xdh_tag             o_tag,
    output logic [xdh_pkg::XDH_VAL_W-1:0] o_mterm
);
    import xdh_pkg::*;

    t_xdh_tag    r_tag_c, r_tag_d, r_tag_e, r_tag_f;
    logic [59:0] r_prod;
    logic [35:0] r_f1;
    logic [29:0] r_drop;
    logic [29:0] r_mterm;

    logic [35:0] f1;
    logic [30:0] f2;
    logic [40:0] mp;
    logic [30:0] ms;

    always_comb begin
        f1 = 36'(r_prod[59:30]) * 36'(XDH_FOLD) + 36'(r_prod[29:0]);
        f2 = 31'(r_f1[35:30]) * 31'(XDH_FOLD) + 31'(r_f1[29:0]);
        mp = 41'(r_drop) * 41'(XDH_BASE);
        ms = 31'(mp[40:30]) * 31'(XDH_FOLD) + 31'(mp[29:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_c <= '0;
            r_tag_d <= '0;
            r_tag_e <= '0;
            r_tag_f <= '0;
        end else begin
            r_tag_c <= i_tag;
            r_tag_d <= r_tag_c;
            r_tag_e <= r_tag_d;
            r_tag_f <= r_tag_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= i_tag.drop ? (60'(i_top_pow) * 60'(i_old)) : '0;
        r_f1    <= f1;
        r_drop  <= (f2 >= 31'(XDH_PRIME)) ? 30'(f2 - 31'(XDH_PRIME)) : f2[29:0];
        r_mterm <= (ms >= 31'(XDH_PRIME)) ? 30'(ms - 31'(XDH_PRIME)) : ms[29:0];
    end

    assign o_tag   = r_tag_f;
    assign o_mterm = r_mterm;

endmodule

// ===== sv/xdh_hash_loop.sv =====
// Update term and the running hash register: h = h * base + t, modulo the prime.
`timescale 1ns / 1ps

module xdh_hash_loop (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_clr,
    input  xdh_pkg::t_xdh_tag             i_tag,
    input  logic [xdh_pkg::XDH_VAL_W-1:0] i_mterm,
    output logic                          o_push,
    output logic [xdh_pkg::XDH_VAL_W-1:0] o_hash,
    output logic [xdh_pkg::XDH_POS_W-1:0] o_pos
);
    import xdh_pkg::*;

    t_xdh_tag    r_tag_g;
    logic [29:0] r_t;
    logic [29:0] r_hash;

    logic [29:0] dm;
    logic [30:0] t_sum;
    logic [40:0] hp;
    logic [31:0] v;
    logic [29:0] n_hash;

    always_comb begin
        // Difference enters by its residue; subtract the scaled drop term.
        dm    = (i_tag.diff >= XDH_PRIME) ? i_tag.diff - XDH_PRIME : i_tag.diff;
        t_sum = (dm >= i_mterm) ? 31'(dm) - 31'(i_mterm)
                                : 31'(dm) + 31'(XDH_PRIME) - 31'(i_mterm);
        hp    = 41'(r_hash) * 41'(XDH_BASE);
        v     = 32'(hp[29:0]) + 32'(hp[40:30]) * 32'(XDH_FOLD) + 32'(r_t);
        if (v >= XDH_PRIME2) begin
            n_hash = 30'(v - XDH_PRIME2);
        end else if (v >= 32'(XDH_PRIME)) begin
            n_hash = 30'(v - 32'(XDH_PRIME));
        end else begin
            n_hash = v[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= t_sum[29:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_g <= '0;
            r_hash  <= '0;
        end else begin
            r_tag_g <= i_tag;
            if (i_cfg_clr) begin
                r_hash <= '0;
            end else if (r_tag_g.vld) begin
                r_hash <= r_tag_g.clr ? '0 : n_hash;
            end
        end
    end

    assign o_push = r_tag_g.vld && r_tag_g.emit;
    assign o_hash = n_hash;
    assign o_pos  = r_tag_g.pos;

endmodule

// ===== sv/xdh_out_fifo.sv =====
// Result queue with slot reservation at input acceptance.
`timescale 1ns / 1ps

module xdh_out_fifo #(
    parameter int DEPTH = xdh_pkg::XDH_OUT_DEPTH,
    parameter int DW    = xdh_pkg::XDH_VAL_W + xdh_pkg::XDH_POS_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_reserve,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);
    import xdh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count, r_used;
    logic          pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_used < CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_used  <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
            r_used  <= r_used + CW'(i_reserve) - CW'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_in_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_used)
        else $error("queue holds more results than were reserved");
    a_reserve_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_reserve |-> r_used < CW'(DEPTH))
        else $error("slot reserved with no room");
    a_push_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> r_count < CW'(DEPTH))
        else $error("result pushed into a full queue");
`endif

endmodule

// ===== sv/xor_delta_rolling_window_hash_top.sv =====
// Top level of the XOR-delta rolling window hash.
`timescale 1ns / 1ps

// Takes one raw 30-bit value per cycle, forms the XOR with the previous raw value and keeps
// a base-1031 polynomial hash, modulo 2^30-35, over the last window_length differences.
// Once the window is full, every item emits the window hash and the position of the raw
// value ending it. A restart item (tuser set) primes the XOR, zeroes the position and
// empties the window without a result. Throughput is one item per cycle while s_axis_tready
// is high: the window store is a single memory with one write and one read port, each used
// once per item, and the hash register closes a one-cycle multiply-by-base-and-add loop,
// with the drop term prepared in earlier stages. A result is registered in the tag register
// b, the drop-unit registers c to f and the hash stage g, then queued and offered on m_axis.
// Results wait in a 16-entry queue; a slot is reserved when an item that yields a result
// is accepted, so s_axis_tready falls only while 16 results are in flight or unread.
// Write window_length and top_power only while no item is in flight; a window_length write
// also empties the window. top_power must hold 1031^(window_length-1) mod the prime.
module xor_delta_rolling_window_hash_top #(
    parameter int MAX_WINDOW = xdh_pkg::XDH_MAX_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [29:0] raw_value, [31:30] zero
    input  logic [0:0]  s_axis_tuser,    // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // [29:0] window_hash, [45:30] end_position, [47:46] 0
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_wdata
);
    import xdh_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = ($clog2(MAX_WINDOW + 1) > XDH_LEN_W) ? $clog2(MAX_WINDOW + 1)
                                                             : XDH_LEN_W;
    localparam int IW = CW + 1;

    // Configuration: effective window length held already clamped.
    logic [CW-1:0]        r_wlen;
    logic [XDH_VAL_W-1:0] r_top_pow;
    logic [CW-1:0]        cfg_len;
    logic                 cfg_clr;

    // Front-end state.
    logic [XDH_VAL_W-1:0] r_prev;
    logic [XDH_POS_W-1:0] r_pos;
    logic [CW-1:0]        r_fill;
    logic [AW-1:0]        r_wp;

    logic                 accept;
    logic                 restart;
    logic [XDH_VAL_W-1:0] raw;
    logic [XDH_VAL_W-1:0] diff;
    logic                 drop;
    logic                 emit;
    logic [CW-1:0]        fill_inc;
    logic [IW-1:0]        rd_sum;
    logic [IW-1:0]        rd_idx;

    t_xdh_tag             n_tag;
    t_xdh_tag             r_tag_b;
    t_xdh_tag             tag_f;
    logic [XDH_VAL_W-1:0] old_val;
    logic [XDH_VAL_W-1:0] mterm;
    logic                 push;
    logic [XDH_VAL_W-1:0] hash_val;
    logic [XDH_POS_W-1:0] hash_pos;
    logic                 room;
    logic [XDH_VAL_W+XDH_POS_W-1:0] q_data;

    assign raw     = s_axis_tdata[XDH_VAL_W-1:0];
    assign restart = s_axis_tuser[0];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;

    // Clamp the written length into 1..MAX_WINDOW.
    always_comb begin
        cfg_len = CW'(i_cfg_wdata[XDH_LEN_W-1:0]);
        if (cfg_len == '0) begin
            cfg_len = CW'(1);
        end else if (cfg_len > CW'(MAX_WINDOW)) begin
            cfg_len = CW'(MAX_WINDOW);
        end
        cfg_clr = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_WIN_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= CW'(1);
            r_top_pow <= XDH_VAL_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIN_LEN: r_wlen    <= cfg_len;
                CFG_TOP_POW: r_top_pow <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: difference, fill bookkeeping and the address of the value leaving the window.
    always_comb begin
        diff     = raw ^ r_prev;
        drop     = (r_fill >= r_wlen);
        fill_inc = r_fill + 1'b1;
        emit     = !restart && (drop || (fill_inc >= r_wlen));
        rd_sum   = IW'(r_wp) + IW'(MAX_WINDOW) - IW'(r_wlen);
        rd_idx   = (rd_sum >= IW'(MAX_WINDOW)) ? rd_sum - IW'(MAX_WINDOW) : rd_sum;

        n_tag      = '0;
        n_tag.vld  = accept;
        n_tag.clr  = restart;
        n_tag.drop = !restart && drop;
        n_tag.emit = emit;
        n_tag.diff = diff;
        n_tag.pos  = restart ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_b <= n_tag;
            if (cfg_clr) begin
                r_fill <= '0;
            end else if (accept) begin
                r_prev <= raw;
                r_pos  <= n_tag.pos;
                if (restart) begin
                    r_fill <= '0;
                end else begin
                    // Saturate the fill count at the window length.
                    if (!drop) begin
                        r_fill <= fill_inc;
                    end
                    r_wp <= (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                end
            end
        end
    end

    xdh_win_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (accept && !restart),
        .i_waddr (r_wp),
        .i_wdata (diff),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (old_val)
    );

    xdh_drop_unit u_drop (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (r_tag_b),
        .i_old     (old_val),
        .i_top_pow (r_top_pow),
        .o_tag     (tag_f),
        .o_mterm   (mterm)
    );

    xdh_hash_loop u_loop (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_clr (cfg_clr),
        .i_tag     (tag_f),
        .i_mterm   (mterm),
        .o_push    (push),
        .o_hash    (hash_val),
        .o_pos     (hash_pos)
    );

    xdh_out_fifo #(
        .DEPTH (XDH_OUT_DEPTH),
        .DW    (XDH_VAL_W + XDH_POS_W)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (accept && emit),
        .i_push    (push),
        .i_data    ({hash_pos, hash_val}),
        .o_room    (room),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (q_data)
    );

    assign m_axis_tdata = {2'b00, q_data};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_wlen)
        else $error("fill count beyond window length");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wlen != '0) && (r_wlen <= CW'(MAX_WINDOW)))
        else $error("window length outside its clamped range");
    a_drop_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag_b.vld && r_tag_b.drop) |-> (r_tag_b.emit && !r_tag_b.clr))
        else $error("full-window item without a result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the XOR-delta rolling window hash top level.
`timescale 1ns / 1ps

// Streams raw values, with and without restarts, through the block and checks every
// window hash and end position against a predictor kept inside this module.
// A queue of pending transfers and register writes is filled at time zero. A
// negedge-clocked driver works through it. A posedge-clocked monitor updates the
// predictor on every accepted input transfer and on every register write. It compares
// each result transfer with the oldest expected hash.
// Register writes wait until the expected-hash queue is empty and the pipeline had time
// to drain items that produce no result.
module tb_top;
    import xdh_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RST_CYCLES   = 8;
    localparam int          DRAIN_CYCLES = 16;      // well past the pipeline latency
    localparam int          END_WAIT     = 20;
    localparam longint      CYCLE_LIMIT  = 500000;
    localparam int          RAND_ITEMS   = 1400;
    localparam int          LONG_ITEMS   = 200;     // one unbroken back-to-back sequence
    localparam logic [1:0]  CFG_IDX_SPARE = 2'd3;   // not a register, writes are dropped
    localparam logic [63:0] HASH_MUL     = 64'd1031;

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_CFG,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind  kind;
        logic [29:0] raw;
        logic        restart;
        logic [1:0]  idx;
        logic [29:0] wdata;
        logic        tight;     // no sender gap, no receiver stall
    } t_stim;

    typedef struct packed {
        logic [29:0] hash;
        logic [15:0] pos;
    } t_hash_result;

    // DUT ports; the inputs are known from time zero.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = '0;
    logic [0:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_idx      = '0;
    logic [29:0] i_cfg_wdata    = '0;

    // Stimulus and scoreboard.
    t_stim        stim_q[$];
    t_hash_result hash_q[$];
    logic         item_taken = 1'b0;
    logic         out_taken  = 1'b0;
    logic         sink_tight = 1'b0;
    int           gap_left   = 0;
    int           stall_left = 0;
    int           quiet_cnt  = 0;
    int           err_cnt    = 0;
    longint       cycle_cnt  = 0;
    int           rand_items = 0;
    logic [29:0]  last_raw   = '0;

    // Predictor state.
    logic [8:0]   cur_len   = 9'd1;
    logic [29:0]  cur_pow   = 30'd1;
    logic [29:0]  prev_raw  = '0;
    logic [29:0]  delta_mem [XDH_MAX_WINDOW];
    logic [29:0]  roll_hash = '0;
    int unsigned  filled    = 0;
    logic [7:0]   wr_ptr    = '0;
    logic [15:0]  seq_pos   = '0;

    xor_delta_rolling_window_hash_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [29:0] raw_value, [31:30] zero
        .s_axis_tuser  (s_axis_tuser),     // [0] restart
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [29:0] window_hash, [45:30] end_position
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Clamp a programmed window length to the span the block really covers.
    function automatic int unsigned window_span(input int unsigned len);
        if (len == 0) begin
            return 1;
        end
        return (len > XDH_MAX_WINDOW) ? XDH_MAX_WINDOW : len;
    endfunction

    // 1031^(span-1) mod prime, the weight of the oldest difference in the window.
    function automatic logic [29:0] base_power(input int unsigned len);
        logic [63:0] p;
        int unsigned span;
        p = 64'd1;
        span = window_span(len);
        for (int unsigned k = 1; k < span; k++) begin
            p = (p * HASH_MUL) % 64'(XDH_PRIME);
        end
        return p[29:0];
    endfunction

    // Advance the predictor by one input transfer; emit is set when the window is full.
    function automatic void advance_hash(input logic [29:0] raw, input logic rs,
                                         output logic emit, output t_hash_result res);
        logic [29:0] delta;
        int unsigned span;
        logic [7:0]  old_idx;
        logic [63:0] acc;
        logic [63:0] drop;
        emit = 1'b0;
        res  = '0;
        span = window_span(cur_len);
        if (rs) begin
            // Prime the XOR and start the window over.
            prev_raw  = raw;
            seq_pos   = '0;
            filled    = 0;
            roll_hash = '0;
            return;
        end
        delta    = raw ^ prev_raw;
        prev_raw = raw;
        seq_pos  = seq_pos + 16'd1;
        acc      = 64'(roll_hash);
        if (filled >= span) begin
            // Remove the oldest difference, weighted by the programmed power.
            old_idx = wr_ptr - 8'(span);
            drop    = (64'(cur_pow) * 64'(delta_mem[old_idx])) % 64'(XDH_PRIME);
            acc     = (acc + 64'(XDH_PRIME) - drop) % 64'(XDH_PRIME);
        end else begin
            filled++;
        end
        acc = (acc * HASH_MUL + 64'(delta)) % 64'(XDH_PRIME);
        roll_hash = acc[29:0];
        delta_mem[wr_ptr] = delta;
        wr_ptr = wr_ptr + 8'd1;
        if (filled >= span) begin
            emit     = 1'b1;
            res.hash = roll_hash;
            res.pos  = seq_pos;
        end
    endfunction

    // Raw values: extremes, single-bit steps from the last value, and plain noise.
    function automatic logic [29:0] next_raw();
        logic [29:0] v;
        case ($urandom_range(0, 9)) inside
            0:       v = '0;
            1:       v = '1;
            [2:3]:   v = last_raw ^ (30'd1 << $urandom_range(0, 29));
            default: v = 30'($urandom);
        endcase
        last_raw = v;
        return v;
    endfunction

    task automatic push_item(input logic [29:0] raw, input logic rs, input logic tight);
        t_stim s;
        s = '{kind: STIM_ITEM, raw: raw, restart: rs, idx: '0, wdata: '0, tight: tight};
        stim_q.insert(stim_q.size(), s);
    endtask

    // A register write or a bare pause; both wait for the pipeline to drain.
    task automatic push_hold(input t_stim_kind kind, input logic [1:0] idx,
                             input logic [29:0] data);
        t_stim s;
        s = '{kind: kind, raw: '0, restart: 1'b0, idx: idx, wdata: data, tight: 1'b0};
        stim_q.insert(stim_q.size(), s);
    endtask

    // One random phase: new register settings, then a run of mostly well-formed sequences.
    task automatic queue_phase(input int p);
        int unsigned len;
        int unsigned span;
        int unsigned n;
        logic [29:0] pow;
        logic        tight;
        logic        rs;
        if (p == 1) begin
            len = 511;                      // above the maximum, acts as full depth
        end else if (p == 3) begin
            len = XDH_MAX_WINDOW;
        end else if (p % 5 == 4) begin
            len = $urandom_range(13, 300);
        end else begin
            len = $urandom_range(0, 12);
        end
        span = window_span(len);
        if (p % 4 == 2) begin
            // Deliberately inconsistent power: the update rule still defines the hash.
            case ($urandom_range(0, 2))
                0:       pow = '0;
                1:       pow = '1;
                default: pow = 30'($urandom);
            endcase
        end else begin
            pow = base_power(span);
        end
        tight = (p % 3 == 0);
        n = (span > 12) ? span + $urandom_range(20, 60) : $urandom_range(40, 120);
        if ($urandom_range(0, 1) == 0) begin
            push_hold(STIM_CFG, CFG_WIN_LEN, 30'(len));
            push_hold(STIM_CFG, CFG_TOP_POW, pow);
        end else begin
            push_hold(STIM_CFG, CFG_TOP_POW, pow);
            push_hold(STIM_CFG, CFG_WIN_LEN, 30'(len));
        end
        // Most phases open a fresh sequence; the rest continue the previous one.
        if ($urandom_range(0, 9) < 7) begin
            push_item(next_raw(), 1'b1, tight);
        end
        for (int unsigned i = 0; i < n; i++) begin
            rs = (span <= 12) && ($urandom_range(0, 19) == 0);
            push_item(next_raw(), rs, tight);
            // Hold the sender once until every hash is back.
            if (p == 2 && i == n / 2) begin
                push_hold(STIM_DRAIN, CFG_WIN_LEN, '0);
            end
        end
        rand_items += n;
    endtask

    // Driver: change inputs on the falling edge, one assignment per signal per edge.
    always @(negedge i_clk) begin
        t_stim       nxt;
        logic        valid_n;
        logic [31:0] data_n;
        logic [0:0]  user_n;
        logic        we_n;
        logic [1:0]  idx_n;
        logic [29:0] wdata_n;
        logic        tight_n;
        valid_n = s_axis_tvalid && !item_taken;
        data_n  = s_axis_tdata;
        user_n  = s_axis_tuser;
        we_n    = 1'b0;
        idx_n   = i_cfg_idx;
        wdata_n = i_cfg_wdata;
        tight_n = sink_tight;
        if (i_rst_n && !valid_n) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (stim_q.size() != 0) begin
                nxt = stim_q[0];
                if (nxt.kind == STIM_ITEM) begin
                    valid_n   = 1'b1;
                    data_n    = {2'b00, nxt.raw};
                    user_n    = nxt.restart;
                    tight_n   = nxt.tight;
                    gap_left  = nxt.tight ? 0 : $urandom_range(0, 5);
                    quiet_cnt = 0;
                    void'(stim_q.pop_front());
                end else begin
                    // Count quiet cycles; restarts and filling items may still be in flight.
                    quiet_cnt = (hash_q.size() == 0) ? quiet_cnt + 1 : 0;
                    if (quiet_cnt >= DRAIN_CYCLES) begin
                        if (nxt.kind == STIM_CFG) begin
                            we_n    = 1'b1;
                            idx_n   = nxt.idx;
                            wdata_n = nxt.wdata;
                        end
                        quiet_cnt = 0;
                        void'(stim_q.pop_front());
                    end
                end
            end
        end
        s_axis_tvalid <= valid_n;
        s_axis_tdata  <= data_n;
        s_axis_tuser  <= user_n;
        i_cfg_we      <= we_n;
        i_cfg_idx     <= idx_n;
        i_cfg_wdata   <= wdata_n;
        sink_tight    <= tight_n;
    end

    // Receiver: after each result transfer, stall for a drawn number of cycles.
    always @(negedge i_clk) begin
        logic ready_n;
        if (out_taken) begin
            stall_left = sink_tight ? 0 : $urandom_range(0, 5);
        end
        if (!i_rst_n) begin
            ready_n = 1'b0;
        end else if (stall_left != 0) begin
            ready_n = 1'b0;
            stall_left--;
        end else begin
            ready_n = 1'b1;
        end
        m_axis_tready <= ready_n;
    end

    // Monitor: sample on the rising edge, update the predictor, check results.
    always @(posedge i_clk) begin
        logic         emit;
        t_hash_result res;
        t_hash_result exp_r;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("xor_delta_rolling_window_hash_top verification failed");
            $finish;
        end else begin
            item_taken <= s_axis_tvalid && s_axis_tready;
            out_taken  <= m_axis_tvalid && m_axis_tready;
            if (i_rst_n) begin
                if (i_cfg_we) begin
                    case (i_cfg_idx)
                        CFG_WIN_LEN: begin
                            // A new length also empties the window.
                            cur_len   = i_cfg_wdata[8:0];
                            filled    = 0;
                            roll_hash = '0;
                        end
                        CFG_TOP_POW: begin
                            cur_pow = i_cfg_wdata;
                        end
                        default: begin
                        end
                    endcase
                end
                if (s_axis_tvalid && s_axis_tready) begin
                    advance_hash(s_axis_tdata[29:0], s_axis_tuser[0], emit, res);
                    if (emit) begin
                        hash_q.insert(hash_q.size(), res);
                    end
                end
                if (m_axis_tvalid && m_axis_tready) begin
                    if (hash_q.size() == 0) begin
                        $error("unexpected result: window_hash %0d end_position %0d",
                               m_axis_tdata[29:0], m_axis_tdata[45:30]);
                        err_cnt++;
                    end else begin
                        exp_r = hash_q.pop_front();
                        if (m_axis_tdata[29:0] !== exp_r.hash) begin
                            $error("window_hash mismatch: expected %0d, got %0d",
                                   exp_r.hash, m_axis_tdata[29:0]);
                            err_cnt++;
                        end
                        if (m_axis_tdata[45:30] !== exp_r.pos) begin
                            $error("end_position mismatch: expected %0d, got %0d",
                                   exp_r.pos, m_axis_tdata[45:30]);
                            err_cnt++;
                        end
                    end
                end
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin
        logic [29:0] at_prime;
        int p;
        at_prime = 30'h3FFF_FFFF ^ XDH_PRIME;

        // Directed: no restart after reset, so the first difference is the raw value.
        // Reset length is 1, so every item hashes just its own difference.
        push_item(30'h3FFF_FFFF, 1'b0, 1'b0);  // difference above the prime
        push_item(at_prime, 1'b0, 1'b0);       // difference equal to the prime
        push_item(at_prime, 1'b0, 1'b0);       // zero difference
        push_item(30'h2AAA_AAAA, 1'b1, 1'b0);  // restart, no result
        push_item(30'h1555_5555, 1'b0, 1'b0);

        // Three-wide window with a restart in the middle of a sequence.
        push_hold(STIM_CFG, CFG_WIN_LEN, 30'd3);
        push_hold(STIM_CFG, CFG_TOP_POW, base_power(3));
        push_item('0, 1'b1, 1'b0);
        push_item(30'h3FFF_FFFF, 1'b0, 1'b0);
        push_item('0, 1'b0, 1'b0);
        push_item(30'h0000_0001, 1'b0, 1'b0);
        push_item(30'h2000_0000, 1'b0, 1'b0);
        push_item(30'h3FFF_FFFE, 1'b0, 1'b0);
        push_item(30'h3FFF_FFFF, 1'b1, 1'b1);
        push_item('0, 1'b0, 1'b1);
        push_item(30'h1234_5678, 1'b0, 1'b1);
        push_item(30'h3FFF_FFFF, 1'b0, 1'b1);

        // Zero length acts as one; a write to an unused index must change nothing.
        // A zero power never drops anything, so the hash keeps accumulating.
        push_hold(STIM_CFG, CFG_WIN_LEN, '0);
        push_hold(STIM_CFG, CFG_IDX_SPARE, 30'h3FFF_FFFF);
        push_hold(STIM_CFG, CFG_TOP_POW, '0);
        push_item(30'h0ABC_DEF0, 1'b0, 1'b0);
        push_item(30'h3FFF_FFFF, 1'b0, 1'b0);
        push_item(30'h1111_1111, 1'b0, 1'b0);
        push_item(30'h0000_0000, 1'b0, 1'b0);

        // All-ones power, beyond the prime.
        push_hold(STIM_CFG, CFG_TOP_POW, 30'h3FFF_FFFF);
        push_item(30'h2222_2222, 1'b0, 1'b0);
        push_item(30'h3333_3333, 1'b0, 1'b0);
        push_item(30'h0000_0001, 1'b0, 1'b0);

        // Random phases until the item budget is used up.
        p = 0;
        while (rand_items < RAND_ITEMS) begin
            queue_phase(p);
            p++;
        end

        // One long back-to-back sequence with a two-wide window.
        push_hold(STIM_CFG, CFG_WIN_LEN, 30'd2);
        push_hold(STIM_CFG, CFG_TOP_POW, base_power(2));
        push_item(next_raw(), 1'b1, 1'b1);
        for (int i = 0; i < LONG_ITEMS; i++) begin
            push_item(next_raw(), 1'b0, 1'b1);
        end

        // Hold reset for a fixed number of cycles, release it on a falling edge.
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transfer to go out and every hash to come back.
        while (stim_q.size() != 0 || s_axis_tvalid || hash_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_WAIT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("xor_delta_rolling_window_hash_top verification clean");
        end else begin
            $display("xor_delta_rolling_window_hash_top verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/xdh_pkg.sv
sv/xdh_win_mem.sv
sv/xdh_drop_unit.sv
sv/xdh_hash_loop.sv
sv/xdh_out_fifo.sv
sv/xor_delta_rolling_window_hash_top.sv
tb/tb_top.sv
